>>> design/assert_macros.svh
// Assertion macros shared by the RTL of the byte-stream CRC block.
// No dependencies; define SYNTH to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property on every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Check that a condition implies another one on the next edge.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

>>> design/crc32dm_pkg.sv
// Package for the dual-mode byte-stream CRC-32: constants and byte update functions.
// No dependencies.
`timescale 1ns / 1ps
package crc32dm_pkg;

  localparam int unsigned CrcW = 32;
  localparam logic [CrcW-1:0] CrcPoly     = 32'h04C1_1DB7;
  localparam logic [CrcW-1:0] CrcPolyRefl = 32'hEDB8_8320;
  localparam logic [CrcW-1:0] CrcOnes     = 32'hFFFF_FFFF;

  typedef enum logic {
    MODE_MPEG2 = 1'b0,
    MODE_IEEE  = 1'b1
  } crc_mode_t;

  // Non-reflected byte update, most significant bit first.
  function automatic logic [CrcW-1:0] crc_msb_byte(input logic [CrcW-1:0] r,
                                                   input logic [7:0] b);
    logic [CrcW-1:0] v;
    v = r ^ {b, 24'h0};
    for (int i = 0; i < 8; i++) begin
      v = v[CrcW-1] ? ({v[CrcW-2:0], 1'b0} ^ CrcPoly) : {v[CrcW-2:0], 1'b0};
    end
    return v;
  endfunction

  // Reflected byte update, least significant bit first.
  function automatic logic [CrcW-1:0] crc_lsb_byte(input logic [CrcW-1:0] r,
                                                   input logic [7:0] b);
    logic [CrcW-1:0] v;
    v = r ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ({1'b0, v[CrcW-1:1]} ^ CrcPolyRefl) : {1'b0, v[CrcW-1:1]};
    end
    return v;
  endfunction

endpackage

>>> design/crc32_dual_mode_byte_stream.sv
// Top level of the dual-mode byte-stream CRC-32 (MPEG-2 or reflected IEEE).
// Depends on crc32dm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
// - Input channel (in_valid/in_ready) carries one message byte per transfer with
//   first_byte, last_byte and seed. first_byte restarts the CRC register: all ones
//   in MPEG-2 mode, seed XOR all ones in IEEE mode (seed chains an earlier CRC).
// - Output channel (out_valid/out_ready) returns one transfer per input byte: the
//   finished CRC of the bytes since the last restart, and is_last copied through.
// - cfg_we/cfg_data write crc_mode (0 = MPEG-2, 1 = IEEE); write it only while idle.
// - Each result is registered in the output register, or in the skid register.
// - Throughput: one byte per cycle while ready. The byte update is an 8-step XOR
//   network between the CRC register and the result register; the CRC register
//   feeds back on itself so each byte sees the previous byte's register directly.
// - Stall: a two-entry output (result register plus skid register) lets a byte be
//   taken while a result waits; in_ready drops only when both entries are full,
//   and the result in the output register holds until out_ready.
// - Reset (rst, synchronous, active high): CRC register to all ones, crc_mode to
//   MPEG-2, both output entries empty. A stream without a first_byte after reset
//   continues from all ones.
module crc32_dual_mode_byte_stream (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  input  logic [31:0] seed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] crc_value,
  output logic        is_last
);

  crc32dm_pkg::crc_mode_t crc_mode;
  logic [31:0] crc_register;
  logic [31:0] crc_base;
  logic [31:0] crc_register_next;
  logic [31:0] result_crc;
  logic        in_fire;
  logic        out_free;
  logic        skid_valid;
  logic [31:0] skid_crc;
  logic        skid_last;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  // Output entry can take a new value this edge.
  assign out_free = !out_valid || out_ready;

  // Pick the starting register, then advance it by one byte in the current mode.
  always_comb begin
    if (crc_mode == crc32dm_pkg::MODE_IEEE) begin
      crc_base          = first_byte ? ~seed : crc_register;
      crc_register_next = crc32dm_pkg::crc_lsb_byte(crc_base, data_byte);
      result_crc        = ~crc_register_next;
    end else begin
      crc_base          = first_byte ? crc32dm_pkg::CrcOnes : crc_register;
      crc_register_next = crc32dm_pkg::crc_msb_byte(crc_base, data_byte);
      result_crc        = crc_register_next;
    end
  end

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_mode <= crc32dm_pkg::MODE_MPEG2;
    end else if (cfg_we) begin
      crc_mode <= crc32dm_pkg::crc_mode_t'(cfg_data);
    end
  end

  // Running CRC register: advance on every accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_register <= crc32dm_pkg::CrcOnes;
    end else if (in_fire) begin
      crc_register <= crc_register_next;
    end
  end

  // Output register and skid register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      if (out_free) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_valid && out_ready) begin
      // Drain the skid entry into the output, or empty the output.
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  // Payload of both entries; no reset needed.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (out_free) begin
        crc_value <= result_crc;
        is_last   <= last_byte;
      end else begin
        skid_crc  <= result_crc;
        skid_last <= last_byte;
      end
    end else if (out_valid && out_ready && skid_valid) begin
      crc_value <= skid_crc;
      is_last   <= skid_last;
    end
  end

  // The skid entry is only ever filled behind a held output.
  `ASSERT_ALWAYS(a_skid_behind_out, clk, rst, !skid_valid || out_valid)
  // Every accepted byte leaves a result pending on the next cycle.
  `ASSERT_NEXT(a_fire_gives_result, clk, rst, in_fire, out_valid)
  // A configuration write lands in the mode register.
  `ASSERT_NEXT(a_cfg_write, clk, rst, cfg_we, crc_mode == $past(cfg_data))

endmodule
